FILE: hdl/smh_pkg.sv
// Shared types, constants and functions for the symbol name hash matcher.
// No dependencies; every other file in hdl/ refers to this package by scope.
package smh_pkg;

   // Field and state widths
   localparam int BYTE_W      = 8;
   localparam int HASH_W      = 28;
   localparam int NAME_HASH_W = 24;
   localparam int QUOT_W      = 5;

   // Largest quotient of a 28-bit hash by the modulus
   localparam int QUOT_MAX = 16;

   localparam logic [NAME_HASH_W-1:0] HASH_MODULUS = 24'd16127999;

   // One request: a name character and its end-of-name mark
   typedef struct packed {
      logic [BYTE_W-1:0] name_byte;
      logic              last_byte;
   } req_type;

   // One response: reduced hash and the target compare
   typedef struct packed {
      logic [NAME_HASH_W-1:0] name_hash;
      logic                   is_match;
   } rsp_type;

   // Hash with its quotient estimate, between quotient and remainder stages
   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [QUOT_W-1:0] quot;
   } quot_type;

   // Shift in one byte, fold the top nibble into bits 7..4 and drop it
   function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W+3:0] sum;
      logic [3:0]        top;
      sum = {h, 4'b0000} + {{(HASH_W+4-BYTE_W){1'b0}}, b};
      top = sum[HASH_W+3:HASH_W];
      return sum[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, top, 4'b0000};
   endfunction

   // Quotient times modulus, as a constant lookup
   function automatic logic [HASH_W-1:0] mod_multiple(input logic [QUOT_W-1:0] q);
      logic [HASH_W-1:0] p;
      p = '0;
      for (int k = 1; k <= QUOT_MAX; k++) begin
         if (q == QUOT_W'(k)) begin
            p = HASH_W'(k) * HASH_W'(HASH_MODULUS);
         end
      end
      return p;
   endfunction

endpackage

FILE: hdl/symbol_name_hash_match_core.sv
// Symbol name hash matcher: takes one name character per request and, on the
// character marked last, returns the PJW/ELF-style hash of the name reduced
// modulo 16127999 together with a flag that it equals the configured target.
// One request is taken every cycle unless req_stall is high; a name's response
// leaves after its last character through the hash register, quotient register and
// response register, and those three registers let requests keep flowing while a response waits.
// Characters not marked last give no response. Write target_hash only while idle.
// Depends on smh_pkg and the smh_hash_stage, smh_quot_stage, smh_rem_stage modules.
module symbol_name_hash_match_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  smh_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output smh_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [smh_pkg::NAME_HASH_W-1:0]   csr_data
);

   logic [smh_pkg::NAME_HASH_W-1:0] target_ff, target_in;
   logic                            s1_valid, s1_ready;
   logic [smh_pkg::HASH_W-1:0]      s1_hash;
   logic                            s2_valid, s2_ready;
   smh_pkg::quot_type               s2_data;

   // Hold the target hash
   assign target_in = csr_write ? csr_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   smh_hash_stage u_hash (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_hash  (s1_hash)
   );

   smh_quot_stage u_quot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_hash   (s1_hash),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   smh_rem_stage u_rem (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .in_data     (s2_data),
      .target_hash (target_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // A response is always fully reduced
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.name_hash < smh_pkg::HASH_MODULUS))
      else $error("response hash not reduced");

   // The match flag agrees with the target register
   a_match_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_match == (rsp_data.name_hash == target_ff)))
      else $error("match flag disagrees with target");

   // Never stall a request while the completed-name register is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |-> !req_stall)
      else $error("request stalled with empty hash stage");

   // No response right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

FILE: hdl/smh_hash_stage.sv
// Running hash register and the completed-name register behind it.
// Depends on smh_pkg for the request type and the hash step function.
module smh_hash_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  smh_pkg::req_type              req_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [smh_pkg::HASH_W-1:0]    out_hash
);

   logic [smh_pkg::HASH_W-1:0] running_ff, running_in;
   logic [smh_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic                       valid_ff, valid_in;
   logic [smh_pkg::HASH_W-1:0] step;
   logic                       accept;
   logic                       finish;

   // Stall only while a completed name cannot move on
   assign req_stall = valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign finish    = accept && req_data.last_byte;
   assign step      = smh_pkg::hash_step(running_ff, req_data.name_byte);

   // Advance the running hash; restart it after the last byte
   always_comb begin
      running_in = running_ff;
      if (accept) begin
         running_in = req_data.last_byte ? '0 : step;
      end
      hash_in  = finish ? step : hash_ff;
      valid_in = finish || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         valid_ff   <= valid_in;
      end
      hash_ff <= hash_in;
   end

   assign out_valid = valid_ff;
   assign out_hash  = hash_ff;

endmodule

FILE: hdl/smh_quot_stage.sv
// Quotient stage: compares the hash against the multiples 1 to QUOT_MAX of the modulus.
// Depends on smh_pkg for widths, the multiple table and the quot_type struct.
module smh_quot_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [smh_pkg::HASH_W-1:0]    in_hash,
   output logic                          out_valid,
   input  logic                          out_ready,
   output smh_pkg::quot_type             out_data
);

   logic [smh_pkg::QUOT_MAX-1:0] ge;
   logic [smh_pkg::QUOT_MAX-1:0] onehot;
   logic [smh_pkg::QUOT_W-1:0]   quot;
   smh_pkg::quot_type            data_ff, data_in;
   logic                         valid_ff, valid_in;
   logic                         load;

   // Thermometer of hash >= k * modulus
   for (genvar k = 0; k < smh_pkg::QUOT_MAX; k++) begin : g_cmp
      assign ge[k] = in_hash >= smh_pkg::mod_multiple(smh_pkg::QUOT_W'(k + 1));
   end

   // Top edge of the thermometer gives the quotient
   assign onehot = ge & ~{1'b0, ge[smh_pkg::QUOT_MAX-1:1]};

   always_comb begin
      quot = '0;
      for (int k = 0; k < smh_pkg::QUOT_MAX; k++) begin
         if (onehot[k]) begin
            quot = quot | smh_pkg::QUOT_W'(k + 1);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Load a new hash or hold while the next stage is busy
   always_comb begin
      data_in  = data_ff;
      if (load) begin
         data_in.hash = in_hash;
         data_in.quot = quot;
      end
      valid_in = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/smh_rem_stage.sv
// Remainder stage and response register: subtracts the multiple, compares target.
// Depends on smh_pkg for the quot_type and rsp_type structs and the multiple table.
module smh_rem_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  smh_pkg::quot_type                 in_data,
   input  logic [smh_pkg::NAME_HASH_W-1:0]   target_hash,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output smh_pkg::rsp_type                  rsp_data
);

   logic [smh_pkg::HASH_W-1:0] diff;
   smh_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       valid_ff, valid_in;
   logic                       load;

   // Remainder is below the modulus, so the low 24 bits hold it all
   assign diff = in_data.hash - smh_pkg::mod_multiple(in_data.quot);

   assign in_ready = !valid_ff || !rsp_stall;
   assign load     = in_valid && in_ready;

   // Capture a response or hold it while stalled
   always_comb begin
      rsp_in = rsp_ff;
      if (load) begin
         rsp_in.name_hash = diff[smh_pkg::NAME_HASH_W-1:0];
         rsp_in.is_match  = diff[smh_pkg::NAME_HASH_W-1:0] == target_hash;
      end
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
